// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("invariant violated");

// same-cycle implication outside reset
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication violated");

`endif

// ===== design/dats_pkg.sv =====
package dats_pkg;

	localparam int CMD_ID_W     = 11;
	localparam int TIME_W       = 17;
	localparam int DUR_W        = 16;
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 17;
	localparam int QDEPTH       = 4;
	localparam int QAW          = $clog2(QDEPTH);
	localparam int QCW          = $clog2(QDEPTH + 1);

	localparam logic [CMD_ID_W-1:0] COMMAND_ID_RST = 11'h100;
	localparam logic [TIME_W-1:0]   TIMEOUT_RST    = 17'd10000;
	localparam logic [TIME_W-1:0]   ELAPSED_MAX    = 17'h1FFFF;
	localparam logic [7:0]          START_MARK     = 8'hFF;
	localparam logic [7:0]          CODE_EXTEND    = 8'h01;
	localparam logic [7:0]          CODE_RETRACT   = 8'h02;
	localparam logic [1:0]          AWAKE_ALL      = 2'b11;
	localparam logic [1:0]          AWAKE_NONE     = 2'b00;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_COMMAND_ID = 1'b0,
		CFG_TIMEOUT_MS = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		KIND_FRAME = 1'b0,
		KIND_TICK  = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		DIR_STOP    = 2'd0,
		DIR_EXTEND  = 2'd1,
		DIR_RETRACT = 2'd2
	} dir_t;

	typedef enum logic [1:0] {
		ST_PREPARED = 2'd0,
		ST_MOVING   = 2'd1,
		ST_DONE     = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		OP_IGNORE  = 2'd0,
		OP_PREPARE = 2'd1,
		OP_START   = 2'd2,
		OP_TICK    = 2'd3
	} op_t;

	typedef struct packed {
		op_t              op;
		dir_t             dir_one;
		dir_t             dir_two;
		logic [DUR_W-1:0] dur_one;
		logic [DUR_W-1:0] dur_two;
	} cmd_t;

	function automatic dir_t decode_dir(logic [7:0] b);
		dir_t d;
		if (b == CODE_EXTEND) d = DIR_EXTEND;
		else if (b == CODE_RETRACT) d = DIR_RETRACT;
		else d = DIR_STOP;
		return d;
	endfunction

	// {reverse, forward} pin pair for a direction
	function automatic logic [1:0] pins_for(dir_t d);
		logic [1:0] p;
		p = {d == DIR_RETRACT, d == DIR_EXTEND};
		return p;
	endfunction

endpackage

// ===== design/dats_front.sv =====
module dats_front (
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           kind,
	input  logic [dats_pkg::CMD_ID_W-1:0]  frame_id,
	input  logic                           frame_standard,
	input  logic                           frame_is_data,
	input  logic [7:0]                     byte0,
	input  logic [7:0]                     byte1,
	input  logic [7:0]                     byte2,
	input  logic [7:0]                     byte3,
	input  logic [7:0]                     byte4,
	input  logic [7:0]                     byte5,
	input  logic [dats_pkg::CMD_ID_W-1:0]  command_id,
	input  logic                           q_full,
	output logic                           push,
	output dats_pkg::cmd_t                 push_cmd
);
	import dats_pkg::*;

	logic is_cmd;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;
	assign is_cmd   = frame_standard && frame_is_data && (frame_id == command_id);

	always_comb begin
		push_cmd.dir_one = decode_dir(byte0);
		push_cmd.dir_two = decode_dir(byte1);
		push_cmd.dur_one = {byte3, byte2};
		push_cmd.dur_two = {byte5, byte4};
		if (kind == KIND_TICK) begin
			push_cmd.op = OP_TICK;
		end else if (!is_cmd) begin
			push_cmd.op = OP_IGNORE;
		end else if (byte0 == START_MARK) begin
			push_cmd.op = OP_START;
		end else begin
			push_cmd.op = OP_PREPARE;
		end
	end

endmodule

// ===== design/dats_queue.sv =====
module dats_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  dats_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output dats_pkg::cmd_t head_cmd
);
	import dats_pkg::*;

	cmd_t           entries_q [QDEPTH];
	logic [QAW-1:0] wr_ptr_q;
	logic [QAW-1:0] rd_ptr_q;
	logic [QCW-1:0] count_q;

	function automatic logic [QAW-1:0] ptr_next(logic [QAW-1:0] p);
		logic [QAW-1:0] n;
		if (p == QAW'(QDEPTH - 1)) n = '0;
		else n = p + QAW'(1);
		return n;
	endfunction

	assign full       = (count_q == QCW'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= ptr_next(wr_ptr_q);
			if (pop) rd_ptr_q <= ptr_next(rd_ptr_q);
			if (push && !pop) count_q <= count_q + QCW'(1);
			else if (pop && !push) count_q <= count_q - QCW'(1);
		end
	end

endmodule

// ===== design/dats_back.sv =====
module dats_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [dats_pkg::TIME_W-1:0]   timeout_ms,
	input  logic                          head_valid,
	input  dats_pkg::cmd_t                head_cmd,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          motor1_forward,
	output logic                          motor1_reverse,
	output logic                          motor2_forward,
	output logic                          motor2_reverse,
	output logic                          motor1_awake,
	output logic                          motor2_awake,
	output logic                          status_valid,
	output logic [1:0]                    status_code
);
	import dats_pkg::*;

	dir_t              dir_one_q, dir_one_d;
	dir_t              dir_two_q, dir_two_d;
	logic [DUR_W-1:0]  dur_one_q, dur_one_d;
	logic [DUR_W-1:0]  dur_two_q, dur_two_d;
	logic              armed_q, armed_d;
	logic              running_q, running_d;
	logic [TIME_W-1:0] elapsed_q, elapsed_d;
	logic [3:0]        pins_q, pins_d;
	logic [1:0]        awake_q, awake_d;
	logic              out_valid_q;
	logic              status_valid_q, status_valid_d;
	status_t           status_code_q, status_code_d;
	logic              done_one, done_two;

	// the state registers double as the output pins, so they advance only on pop
	assign pop = head_valid && (!out_valid_q || out_ready);

	always_comb begin
		dir_one_d      = dir_one_q;
		dir_two_d      = dir_two_q;
		dur_one_d      = dur_one_q;
		dur_two_d      = dur_two_q;
		armed_d        = armed_q;
		running_d      = running_q;
		elapsed_d      = elapsed_q;
		pins_d         = pins_q;
		awake_d        = awake_q;
		status_valid_d = 1'b0;
		status_code_d  = ST_PREPARED;
		done_one       = 1'b0;
		done_two       = 1'b0;
		case (head_cmd.op)
			OP_PREPARE: begin
				dir_one_d      = head_cmd.dir_one;
				dir_two_d      = head_cmd.dir_two;
				dur_one_d      = head_cmd.dur_one;
				dur_two_d      = head_cmd.dur_two;
				armed_d        = 1'b1;
				running_d      = 1'b0;
				status_valid_d = 1'b1;
				status_code_d  = ST_PREPARED;
			end
			OP_START: begin
				if (armed_q) begin
					pins_d         = {pins_for(dir_two_q), pins_for(dir_one_q)};
					status_valid_d = 1'b1;
					if (dur_one_q == '0 && dur_two_q == '0) begin
						awake_d       = AWAKE_NONE;
						armed_d       = 1'b0;
						running_d     = 1'b0;
						status_code_d = ST_DONE;
					end else begin
						awake_d       = AWAKE_ALL;
						elapsed_d     = '0;
						running_d     = 1'b1;
						status_code_d = ST_MOVING;
					end
				end
			end
			OP_TICK: begin
				if (running_q) begin
					if (elapsed_q != ELAPSED_MAX) elapsed_d = elapsed_q + TIME_W'(1);
					done_one = (elapsed_d >= {1'b0, dur_one_q});
					done_two = (elapsed_d >= {1'b0, dur_two_q});
					// a zero duration leaves its bridge driven but counts as done
					if (dur_one_q != '0 && done_one) pins_d[1:0] = 2'b00;
					if (dur_two_q != '0 && done_two) pins_d[3:2] = 2'b00;
					if ((done_one && done_two) || elapsed_d > timeout_ms) begin
						running_d      = 1'b0;
						armed_d        = 1'b0;
						awake_d        = AWAKE_NONE;
						status_valid_d = 1'b1;
						status_code_d  = ST_DONE;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_one_q      <= DIR_STOP;
			dir_two_q      <= DIR_STOP;
			dur_one_q      <= '0;
			dur_two_q      <= '0;
			armed_q        <= 1'b0;
			running_q      <= 1'b0;
			elapsed_q      <= '0;
			pins_q         <= '0;
			awake_q        <= AWAKE_NONE;
			out_valid_q    <= 1'b0;
			status_valid_q <= 1'b0;
			status_code_q  <= ST_PREPARED;
		end else begin
			if (pop) begin
				dir_one_q      <= dir_one_d;
				dir_two_q      <= dir_two_d;
				dur_one_q      <= dur_one_d;
				dur_two_q      <= dur_two_d;
				armed_q        <= armed_d;
				running_q      <= running_d;
				elapsed_q      <= elapsed_d;
				pins_q         <= pins_d;
				awake_q        <= awake_d;
				status_valid_q <= status_valid_d;
				status_code_q  <= status_code_d;
				out_valid_q    <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign motor1_forward = pins_q[0];
	assign motor1_reverse = pins_q[1];
	assign motor2_forward = pins_q[2];
	assign motor2_reverse = pins_q[3];
	assign motor1_awake   = awake_q[0];
	assign motor2_awake   = awake_q[1];
	assign status_valid   = status_valid_q;
	assign status_code    = status_code_q;

	`include "assert_macros.svh"

	`ASSERT_IMPLY(a_run_armed, clk, arst_n, running_q, armed_q)
	`ASSERT_IMPLY(a_run_awake, clk, arst_n, running_q, awake_q == AWAKE_ALL)
	`ASSERT_ALWAYS(a_awake_pair, clk, arst_n, awake_q == AWAKE_ALL || awake_q == AWAKE_NONE)
	`ASSERT_IMPLY(a_code_quiet, clk, arst_n, out_valid_q && !status_valid_q, status_code_q == ST_PREPARED)

endmodule

// ===== design/dual_actuator_timed_move_sequencer_unit.sv =====
// two-motor timed move sequencer for a pair of h-bridge drivers
// input channel (in_valid/in_ready): one event per transfer, either a received
// frame (kind 0) or a one millisecond tick (kind 1); frames matching command_id
// as standard data frames are commands: byte0 0xff starts, anything else prepares
// output channel (out_valid/out_ready): exactly one result per input event,
// carrying bridge pin levels, driver awake levels and an optional status code
// config: cfg_we writes cfg_data into register cfg_index (0 command_id,
// 1 timeout_ms) in the same cycle; write only while no event is in flight
// latency: two cycles from input transfer to result when the output is free
// throughput: one event per cycle, set by the single-cycle update of the
// execution stage; a four-entry event queue separates classify from execute
// receiver stall: the output holds its result, the queue fills and in_ready
// drops after four further events
// reset: pins low, drivers asleep, not armed, command_id 0x100, timeout 10000
module dual_actuator_timed_move_sequencer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [dats_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dats_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            kind,
	input  logic [dats_pkg::CMD_ID_W-1:0]   frame_id,
	input  logic                            frame_standard,
	input  logic                            frame_is_data,
	input  logic [7:0]                      byte0,
	input  logic [7:0]                      byte1,
	input  logic [7:0]                      byte2,
	input  logic [7:0]                      byte3,
	input  logic [7:0]                      byte4,
	input  logic [7:0]                      byte5,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            motor1_forward,
	output logic                            motor1_reverse,
	output logic                            motor2_forward,
	output logic                            motor2_reverse,
	output logic                            motor1_awake,
	output logic                            motor2_awake,
	output logic                            status_valid,
	output logic [1:0]                      status_code
);
	import dats_pkg::*;

	logic [CMD_ID_W-1:0] command_id_q;
	logic [TIME_W-1:0]   timeout_q;
	logic                q_full;
	logic                push;
	cmd_t                push_cmd;
	logic                pop;
	logic                head_valid;
	cmd_t                head_cmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			command_id_q <= COMMAND_ID_RST;
			timeout_q    <= TIMEOUT_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_COMMAND_ID) command_id_q <= cfg_data[CMD_ID_W-1:0];
			if (cfg_index == CFG_TIMEOUT_MS) timeout_q <= cfg_data[TIME_W-1:0];
		end
	end

	dats_front u_front (
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.frame_id       (frame_id),
		.frame_standard (frame_standard),
		.frame_is_data  (frame_is_data),
		.byte0          (byte0),
		.byte1          (byte1),
		.byte2          (byte2),
		.byte3          (byte3),
		.byte4          (byte4),
		.byte5          (byte5),
		.command_id     (command_id_q),
		.q_full         (q_full),
		.push           (push),
		.push_cmd       (push_cmd)
	);

	dats_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	dats_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.timeout_ms     (timeout_q),
		.head_valid     (head_valid),
		.head_cmd       (head_cmd),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.motor1_forward (motor1_forward),
		.motor1_reverse (motor1_reverse),
		.motor2_forward (motor2_forward),
		.motor2_reverse (motor2_reverse),
		.motor1_awake   (motor1_awake),
		.motor2_awake   (motor2_awake),
		.status_valid   (status_valid),
		.status_code    (status_code)
	);

endmodule
